// ===== hdl/ppo_pkg.sv =====
package ppo_pkg;

  localparam int PERIOD_W    = 11;
  localparam int DEN_W       = 12;
  localparam int CFG_INDEX_W = 8;
  localparam int OSC_W       = 32;

  localparam logic [PERIOD_W-1:0] RESET_FAST_PERIOD = 11'd12;
  localparam logic [PERIOD_W-1:0] RESET_SLOW_PERIOD = 11'd26;

  // register indexes on the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FAST_PERIOD = 8'd0,
    REG_SLOW_PERIOD = 8'd1
  } ppo_reg_t;

  // classified work passed from front to back
  typedef struct packed {
    logic                seed;
    logic [PERIOD_W-1:0] fast_p;
    logic [PERIOD_W-1:0] slow_p;
  } ppo_cmd_t;

  localparam int CMD_W = $bits(ppo_cmd_t);

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } ppo_qstat_t;

endpackage

// ===== hdl/ppo_div.sv =====
module ppo_div #(
  parameter int NW = 48,
  parameter int DW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);
  localparam int CNT_W = $clog2(NW + 1);

  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DW-1:0]    den_r;
  logic [DW:0]      shifted;
  logic [DW:0]      diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, quo[NW-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  // count iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

// ===== hdl/ppo_queue.sv =====
module ppo_queue #(
  parameter int W = 55
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [W-1:0]       din,
  input  logic               pop,
  output logic [W-1:0]       dout,
  output logic               valid,
  output ppo_pkg::ppo_qstat_t stat
);
  import ppo_pkg::*;

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign valid      = count != 2'd0;
  assign stat.full  = count == 2'd2;
  assign stat.empty = count == 2'd0;
  assign dout       = slots[rd_ptr];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // hold entries
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

// ===== hdl/ppo_front.sv =====
module ppo_front #(
  parameter int MAX_PERIOD = 1024,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ppo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppo_pkg::PERIOD_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PRICE_BITS-1:0]             price,
  input  logic                              q_full,
  output logic                              q_push,
  output ppo_pkg::ppo_cmd_t                 q_cmd,
  output logic [PRICE_BITS-1:0]             q_price
);
  import ppo_pkg::*;

  logic [PERIOD_W-1:0] fast_period;
  logic [PERIOD_W-1:0] slow_period;
  logic                seeded;
  logic [PERIOD_W-1:0] pf;
  logic [PERIOD_W-1:0] ps;

  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
    logic [PERIOD_W-1:0] r;
    r = p;
    if (p == '0) r = PERIOD_W'(1);
    else if (int'(p) > MAX_PERIOD) r = PERIOD_W'(MAX_PERIOD);
    return r;
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period <= RESET_FAST_PERIOD;
      slow_period <= RESET_SLOW_PERIOD;
    end else if (cfg_we) begin
      if (cfg_index == REG_FAST_PERIOD) fast_period <= cfg_data;
      if (cfg_index == REG_SLOW_PERIOD) slow_period <= cfg_data;
    end
  end

  // clamp and order the periods, mark the seeding item
  always_comb begin
    pf = clamp_period(fast_period);
    ps = clamp_period(slow_period);
    q_cmd.seed   = !seeded;
    q_cmd.fast_p = (pf > ps) ? ps : pf;
    q_cmd.slow_p = (pf > ps) ? pf : ps;
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;
  assign q_price  = price;

  always_ff @(posedge clk) begin
    if (rst) seeded <= 1'b0;
    else if (q_push) seeded <= 1'b1;
  end

endmodule

// ===== hdl/ppo_back.sv =====
module ppo_back #(
  parameter int PRICE_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  ppo_pkg::ppo_cmd_t              q_cmd,
  input  logic [PRICE_BITS-1:0]          q_price,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [ppo_pkg::OSC_W-1:0] oscillator
);
  import ppo_pkg::*;

  localparam int AW  = PRICE_BITS + 16;
  localparam int RNW = AW + 23;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EMA   = 9'b000000010,
    S_STEP  = 9'b000000100,
    S_APPLY = 9'b000001000,
    S_DIFF  = 9'b000010000,
    S_RGO   = 9'b000100000,
    S_RWAIT = 9'b001000000,
    S_ROUND = 9'b010000000,
    S_OUT   = 9'b100000000
  } ppo_state_t;

  ppo_state_t state;

  logic [AW-1:0]    fast_avg, slow_avg;
  logic [AW-1:0]    f_d, s_d, f_step, s_step, diff;
  logic             f_up, s_up, neg;
  logic [DEN_W-1:0] f_den, s_den;
  logic [OSC_W-1:0] res;

  logic [AW-1:0]    x;
  logic [AW-1:0]    f_abs, s_abs;
  logic [DEN_W-1:0] f_den_c, s_den_c;
  logic             ema_start;
  logic             f_done, s_done;
  logic [AW-1:0]    f_quo, s_quo;
  logic [DEN_W-1:0] f_rem, s_rem;
  logic             r_start, r_done;
  logic [RNW-1:0]   r_num, r_quo;
  logic [AW-1:0]    r_rem;
  logic [AW+6:0]    num100;
  logic             rb, sat;
  logic [OSC_W-1:0] mag;

  // rounded step 2*d/den, never beyond d
  function automatic logic [AW-1:0] ema_step(input logic [AW-1:0] q,
                                             input logic [DEN_W-1:0] r,
                                             input logic [DEN_W-1:0] den,
                                             input logic [AW-1:0] d);
    logic [DEN_W+1:0] sum;
    logic [1:0]       c;
    logic [AW:0]      st;
    sum = {1'b0, r, 1'b0} + {3'b0, den[DEN_W-1:1]};
    if (sum >= {1'b0, den, 1'b0}) c = 2'd2;
    else if (sum >= {2'b0, den}) c = 2'd1;
    else c = 2'd0;
    st = {q, 1'b0} + (AW+1)'(c);
    return (st > {1'b0, d}) ? d : st[AW-1:0];
  endfunction

  // distances of the new price to both averages
  always_comb begin
    x       = {q_price, 16'b0};
    f_abs   = (x >= fast_avg) ? x - fast_avg : fast_avg - x;
    s_abs   = (x >= slow_avg) ? x - slow_avg : slow_avg - x;
    f_den_c = {1'b0, q_cmd.fast_p} + DEN_W'(1);
    s_den_c = {1'b0, q_cmd.slow_p} + DEN_W'(1);
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign ema_start = q_pop && !q_cmd.seed;
  assign r_start   = state == S_RGO;

  ppo_div #(.NW(AW), .DW(DEN_W)) u_fast_div (
    .clk(clk), .rst(rst), .start(ema_start), .num(f_abs), .den(f_den_c),
    .done(f_done), .quo(f_quo), .rem(f_rem)
  );

  ppo_div #(.NW(AW), .DW(DEN_W)) u_slow_div (
    .clk(clk), .rst(rst), .start(ema_start), .num(s_abs), .den(s_den_c),
    .done(s_done), .quo(s_quo), .rem(s_rem)
  );

  // scale the difference by 100 * 2^16
  always_comb begin
    num100 = ((AW+7)'(diff) << 6) + ((AW+7)'(diff) << 5) + ((AW+7)'(diff) << 2);
    r_num  = {num100, 16'b0};
  end

  ppo_div #(.NW(RNW), .DW(AW)) u_ratio_div (
    .clk(clk), .rst(rst), .start(r_start), .num(r_num), .den(slow_avg),
    .done(r_done), .quo(r_quo), .rem(r_rem)
  );

  // round half away from zero, then saturate
  always_comb begin
    rb  = {r_rem, 1'b0} >= {1'b0, slow_avg};
    sat = (|r_quo[RNW-1:31]) || ((r_quo[30:0] == '1) && rb);
    mag = r_quo[OSC_W-1:0] + OSC_W'(rb);
  end

  // sequence one item
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid) state <= q_cmd.seed ? S_OUT : S_EMA;
        end
        S_EMA: begin
          if (f_done && s_done) state <= S_STEP;
        end
        S_STEP:  state <= S_APPLY;
        S_APPLY: state <= S_DIFF;
        S_DIFF:  state <= (slow_avg == '0) ? S_OUT : S_RGO;
        S_RGO:   state <= S_RWAIT;
        S_RWAIT: begin
          if (r_done) state <= S_ROUND;
        end
        S_ROUND: state <= S_OUT;
        S_OUT: begin
          if (!out_valid || out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          if (q_cmd.seed) begin
            fast_avg <= x;
            slow_avg <= x;
            res      <= '0;
          end
          f_up  <= x >= fast_avg;
          s_up  <= x >= slow_avg;
          f_d   <= f_abs;
          s_d   <= s_abs;
          f_den <= f_den_c;
          s_den <= s_den_c;
        end
      end
      S_STEP: begin
        f_step <= ema_step(f_quo, f_rem, f_den, f_d);
        s_step <= ema_step(s_quo, s_rem, s_den, s_d);
      end
      S_APPLY: begin
        fast_avg <= f_up ? fast_avg + f_step : fast_avg - f_step;
        slow_avg <= s_up ? slow_avg + s_step : slow_avg - s_step;
      end
      S_DIFF: begin
        res  <= '0;
        neg  <= fast_avg < slow_avg;
        diff <= (fast_avg < slow_avg) ? slow_avg - fast_avg : fast_avg - slow_avg;
      end
      S_ROUND: begin
        if (sat) res <= neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else res <= neg ? (~mag + 32'd1) : mag;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || out_ready)) oscillator <= res;
  end

endmodule

// ===== hdl/percentage_price_oscillator.sv =====
// Percentage price oscillator over a fast and a slow exponential average.
// Each later item runs a 48-step serial divide per average (both in parallel,
// at 32-bit prices) and, unless the slow average is zero, a 71-step serial
// divide for the ratio; the seeding item skips all three divides.
// Items are handled one at a time; a two-entry queue takes two more meanwhile.
// Reset: synchronous, clears control state; periods return to 12 and 26, unseeded.
module percentage_price_oscillator #(
  parameter int MAX_PERIOD = 1024,
  parameter int PRICE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ppo_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ppo_pkg::PERIOD_W-1:0]      cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [PRICE_BITS-1:0]             price,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [ppo_pkg::OSC_W-1:0]  oscillator
);
  import ppo_pkg::*;

  localparam int QW = CMD_W + PRICE_BITS;

  ppo_cmd_t              f_cmd, b_cmd;
  logic [PRICE_BITS-1:0] f_price, b_price;
  logic                  q_push, q_pop, q_valid;
  logic [QW-1:0]         q_dout;
  ppo_qstat_t            qstat;

  ppo_front #(.MAX_PERIOD(MAX_PERIOD), .PRICE_BITS(PRICE_BITS)) u_front (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .price(price),
    .q_full(qstat.full), .q_push(q_push), .q_cmd(f_cmd), .q_price(f_price)
  );

  ppo_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .din({f_cmd, f_price}),
    .pop(q_pop), .dout(q_dout), .valid(q_valid), .stat(qstat)
  );

  assign b_cmd   = q_dout[QW-1:PRICE_BITS];
  assign b_price = q_dout[PRICE_BITS-1:0];

  ppo_back #(.PRICE_BITS(PRICE_BITS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_cmd(b_cmd), .q_price(b_price), .q_pop(q_pop),
    .out_valid(out_valid), .out_ready(out_ready), .oscillator(oscillator)
  );

  // no push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    qstat.full |-> !q_push) else $error("queue overflow");

  // no pop from an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !qstat.empty) else $error("queue underflow");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ppo_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [PERIOD_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] price = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OSC_W-1:0] oscillator;

  // predictor state
  logic [PERIOD_W-1:0] fast_reg, slow_reg;
  logic [47:0] fast_ema, slow_ema;
  logic primed;

  logic signed [OSC_W-1:0] osc_expected[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;

  percentage_price_oscillator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .price(price),
    .out_valid(out_valid), .out_ready(out_ready), .oscillator(oscillator)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #60000000;
    $display("percentage_price_oscillator: mismatch");
    $finish;
  end

  function automatic logic [10:0] clamp_period(logic [10:0] p);
    if (p == 0) return 11'd1;
    if (p > 11'd1024) return 11'd1024;
    return p;
  endfunction

  function automatic logic [47:0] smooth(logic [47:0] avg, logic [47:0] x, logic [10:0] p);
    logic [63:0] den, d, q, r, step;
    den = 64'(p) + 1;
    d = (x >= avg) ? 64'(x - avg) : 64'(avg - x);
    q = d / den;
    r = d % den;
    step = 2 * q + (2 * r + den / 2) / den;
    if (step > d) step = d;
    return (x >= avg) ? avg + 48'(step) : avg - 48'(step);
  endfunction

  // advance the predictor by one price and return the expected oscillator
  function automatic logic signed [31:0] predict_oscillator(logic [31:0] px);
    logic [47:0] x;
    logic [10:0] pf, ps, t;
    logic [127:0] num, q, r;
    logic [47:0] d;
    logic neg;
    x = {px, 16'h0};
    pf = clamp_period(fast_reg);
    ps = clamp_period(slow_reg);
    if (pf > ps) begin
      t = pf; pf = ps; ps = t;
    end
    if (!primed) begin
      fast_ema = x; slow_ema = x; primed = 1'b1;
      return 0;
    end
    fast_ema = smooth(fast_ema, x, pf);
    slow_ema = smooth(slow_ema, x, ps);
    if (slow_ema == 0) return 0;
    neg = fast_ema < slow_ema;
    d = neg ? slow_ema - fast_ema : fast_ema - slow_ema;
    num = 128'(d) * 128'd6553600;
    q = num / 128'(slow_ema);
    r = num % 128'(slow_ema);
    if (r >= 128'(slow_ema) - r) q = q + 1;
    if (neg) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(32'(q));
    return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(32'(q));
  endfunction

  // offer one item and hold it until accepted; valid stays up for the next one
  task automatic send_price(logic [31:0] px);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    price <= px;
    osc_expected.push_back(predict_oscillator(px));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (osc_expected.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(ppo_reg_t idx, logic [10:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FAST_PERIOD) fast_reg = val;
    else slow_reg = val;
    @(posedge clk);
  endtask

  // drive the ready side
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // compare each item against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (osc_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: oscillator %0d", oscillator);
      end else if (oscillator !== osc_expected[0]) begin
        mismatches++;
        if (mismatches <= 10)
          $display("oscillator expected %0d got %0d", osc_expected[0], oscillator);
        void'(osc_expected.pop_front());
      end else begin
        void'(osc_expected.pop_front());
      end
    end
  end

  task automatic test_directed();
    send_price(32'h0001_0000);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0);
    send_price(32'h0);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0001);
    wait_drained();
    // unit period tracks price exactly; zero slow average
    write_reg(REG_FAST_PERIOD, 11'd0);
    write_reg(REG_SLOW_PERIOD, 11'd1);
    send_price(32'h0);
    send_price(32'h0);
    send_price(32'h1234_5678);
    wait_drained();
    // swapped and over-range periods, saturation both ways
    write_reg(REG_FAST_PERIOD, 11'h7FF);
    write_reg(REG_SLOW_PERIOD, 11'd1);
    send_price(32'hFFFF_FFFF);
    send_price(32'h0000_0001);
    send_price(32'hFFFF_FFFF);
    wait_drained();
    write_reg(REG_FAST_PERIOD, 11'd1);
    send_price(32'h0000_0001);
    send_price(32'h8000_0000);
    send_price(32'h7FFF_FFFF);
    wait_drained();
  endtask

  task automatic test_random(int count);
    logic [31:0] base;
    base = $urandom;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: send_price($urandom);
        1: send_price(base + $urandom_range(4095) - 2048);
        2: send_price(32'($urandom_range(255)));
        default: send_price(base ^ (32'h1 << $urandom_range(31)));
      endcase
      if ($urandom_range(199) == 0) base = $urandom;
    end
  endtask

  task automatic random_config();
    logic [10:0] f, s;
    f = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(40));
    s = ($urandom_range(3) == 0) ? 11'($urandom) : 11'($urandom_range(60));
    write_reg(REG_FAST_PERIOD, f);
    write_reg(REG_SLOW_PERIOD, s);
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 2000;
    test_random(8);
    wait_drained();
    send_idle_pct = 0;
    test_random(5);
    wait_drained();
  endtask

  initial begin
    fast_reg = RESET_FAST_PERIOD;
    slow_reg = RESET_SLOW_PERIOD;
    fast_ema = '0;
    slow_ema = '0;
    primed = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 50 : 0;
      recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 30 : 0;
      for (int k = 0; k < 3; k++) begin
        wait_drained();
        random_config();
        test_random(210);
      end
    end
    wait_drained();
    if (mismatches == 0 && osc_expected.size() == 0)
      $display("percentage_price_oscillator: match");
    else
      $display("percentage_price_oscillator: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/ppo_pkg.sv
hdl/ppo_div.sv
hdl/ppo_queue.sv
hdl/ppo_front.sv
hdl/ppo_back.sv
hdl/percentage_price_oscillator.sv
verif/testbench.sv
